@@ sv/nhvt_pkg.sv @@
package nhvt_pkg;

    localparam int PITCH_W = 7;
    localparam int NOW_W   = 32;
    localparam int SLOT_W  = 4;

    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic               op;
        logic [PITCH_W-1:0] pitch;
        logic [NOW_W-1:0]   now_us;
    } event_t;

    typedef struct packed {
        logic               evicted_valid;
        logic [PITCH_W-1:0] evicted_pitch;
        logic               found;
        logic [SLOT_W-1:0]  slot;
    } result_t;

endpackage

@@ sv/nhvt_history.sv @@
module nhvt_history #(
    parameter int LAST_SLOT = 7,
    parameter int TIME_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              event_fire,
    input  nhvt_pkg::event_t  event_in,
    output nhvt_pkg::result_t result
);

    localparam int NUM_SLOTS = LAST_SLOT + 1;
    localparam int SLOT_W    = nhvt_pkg::SLOT_W;
    localparam int PITCH_W   = nhvt_pkg::PITCH_W;
    localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(NUM_SLOTS);

    logic [PITCH_W-1:0]   pitch_reg [NUM_SLOTS];
    logic                 valid_reg [NUM_SLOTS];
    logic [TIME_BITS-1:0] stamp_reg [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] match;
    logic                 hit;
    logic [SLOT_W-1:0]    hit_slot;
    logic [NUM_SLOTS-1:0] hit_onehot;
    logic [TIME_BITS-1:0] stamp;
    logic                 is_on;

    assign is_on = (event_in.op == nhvt_pkg::OP_NOTE_ON);
    assign stamp = TIME_BITS'(event_in.now_us);

    always_comb begin
        hit        = 1'b0;
        hit_slot   = NO_SLOT;
        hit_onehot = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            match[i] = valid_reg[i] && (pitch_reg[i] == event_in.pitch);
        end
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit        = 1'b1;
                hit_slot   = SLOT_W'(i);
                hit_onehot = NUM_SLOTS'(1) << i;
            end
        end
    end

    always_comb begin
        result = '0;
        if (is_on) begin
            result.slot          = '0;
            result.found         = 1'b1;
            result.evicted_valid = valid_reg[LAST_SLOT];
            result.evicted_pitch = valid_reg[LAST_SLOT] ? pitch_reg[LAST_SLOT] : '0;
        end else begin
            result.slot  = hit_slot;
            result.found = hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
                pitch_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
        end else if (event_fire) begin
            if (is_on) begin
                for (int i = NUM_SLOTS - 1; i > 0; i--) begin
                    valid_reg[i] <= valid_reg[i-1];
                    pitch_reg[i] <= pitch_reg[i-1];
                    stamp_reg[i] <= stamp_reg[i-1];
                end
                valid_reg[0] <= 1'b1;
                pitch_reg[0] <= event_in.pitch;
                stamp_reg[0] <= '0;
            end else begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (hit_onehot[i]) begin
                        stamp_reg[i] <= stamp;
                    end
                end
            end
        end
    end

endmodule

@@ sv/note_history_voice_tracker_unit.sv @@
// A beat is held in the input register, its result in the output register. Throughput: one
// event per cycle while m_tready does not stall the output; the history registers are updated
// as each event leaves the input register, so the next event already sees the new history.
// Reset: synchronous active-low aresetn empties every slot and drops both stage valids.
module note_history_voice_tracker_unit #(
    parameter int LAST_SLOT = 7,
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pitch[6:0], now_us[38:7], zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // slot[3:0], found[4], evicted_pitch[11:5],
                                   // evicted_valid[12], zero pad
);

    nhvt_pkg::event_t  in_reg;
    logic              in_valid_reg;
    nhvt_pkg::result_t out_reg;
    logic              out_valid_reg;
    nhvt_pkg::result_t result;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.op     <= s_tuser;
            in_reg.pitch  <= s_tdata[6:0];
            in_reg.now_us <= s_tdata[38:7];
        end
    end

    nhvt_history #(
        .LAST_SLOT (LAST_SLOT),
        .TIME_BITS (TIME_BITS)
    ) u_history (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .event_fire (advance),
        .event_in   (in_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule

@@ sv/nhvt_checker.sv @@
module nhvt_checker #(
    parameter int LAST_SLOT = 7
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    localparam logic [3:0] NO_SLOT = 4'(LAST_SLOT + 1);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result beat shown right after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result beat changed.");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |-> m_tdata[3:0] == NO_SLOT && m_tdata[12:5] == 8'h00)
        else $error("Unmatched release carries a slot or an eviction.");

    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[4] && m_tdata[3:0] == 4'd0)
        else $error("Eviction reported outside a note on.");

    a_input_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("Input stalled while the output stage is empty.");

endmodule

bind note_history_voice_tracker_unit nhvt_checker #(.LAST_SLOT(LAST_SLOT)) u_nhvt_checker (.*);

@@ tb/voice_history_checker.sv @@
`timescale 1ns / 100ps

module voice_history_checker #(
    parameter int LAST_SLOT = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int unsigned voice_errors,
    output int unsigned results_owed
);

    localparam int SLOT_W     = nhvt_pkg::SLOT_W;
    localparam int PITCH_W    = nhvt_pkg::PITCH_W;
    localparam int NOW_W      = nhvt_pkg::NOW_W;
    localparam int NUM_VOICES = LAST_SLOT + 1;
    localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(NUM_VOICES);

    logic [PITCH_W-1:0] held_pitch    [NUM_VOICES];
    logic               held_valid    [NUM_VOICES];
    logic [NOW_W-1:0]   release_stamp [NUM_VOICES];
    nhvt_pkg::result_t  owed_results  [$];
    int unsigned        error_total;
    int unsigned        owed_total;

    assign voice_errors = error_total;
    assign results_owed = owed_total;

    function automatic nhvt_pkg::result_t apply_voice_event(input nhvt_pkg::event_t ev);
        nhvt_pkg::result_t res;
        res = '0;
        if (ev.op == nhvt_pkg::OP_NOTE_ON) begin
            res.slot          = '0;
            res.found         = 1'b1;
            res.evicted_valid = held_valid[LAST_SLOT];
            res.evicted_pitch = held_valid[LAST_SLOT] ? held_pitch[LAST_SLOT] : '0;
            for (int i = LAST_SLOT; i > 0; i--) begin
                held_pitch[i]    = held_pitch[i-1];
                held_valid[i]    = held_valid[i-1];
                release_stamp[i] = release_stamp[i-1];
            end
            held_pitch[0]    = ev.pitch;
            held_valid[0]    = 1'b1;
            release_stamp[0] = '0;
        end else begin
            res.slot = NO_SLOT;
            for (int i = 0; i < NUM_VOICES; i++) begin
                if (!res.found && held_valid[i] && held_pitch[i] == ev.pitch) begin
                    release_stamp[i] = ev.now_us;
                    res.slot         = SLOT_W'(i);
                    res.found        = 1'b1;
                end
            end
        end
        return res;
    endfunction

    initial begin
        error_total = 0;
        owed_total  = 0;
    end

    always @(posedge aclk) begin
        nhvt_pkg::result_t got;
        nhvt_pkg::result_t want;
        nhvt_pkg::event_t  ev;
        if (!aresetn) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                held_pitch[i]    = '0;
                held_valid[i]    = 1'b0;
                release_stamp[i] = '0;
            end
            owed_results.delete();
            owed_total = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = nhvt_pkg::result_t'(m_tdata[12:0]);
                if (owed_results.size() == 0) begin
                    if (error_total < 10) begin
                        $display("%0t: result beat with nothing expected, tdata %h",
                                 $time, m_tdata);
                    end
                    error_total++;
                end else begin
                    want = owed_results.pop_front();
                    if (got.slot !== want.slot || got.found !== want.found ||
                        got.evicted_pitch !== want.evicted_pitch ||
                        got.evicted_valid !== want.evicted_valid ||
                        m_tdata[15:13] !== 3'b000) begin
                        if (error_total < 10) begin
                            $display({"%0t: mismatch expected slot %0d found %0d",
                                      " ev_pitch %0d ev_valid %0d"},
                                     $time, want.slot, want.found, want.evicted_pitch,
                                     want.evicted_valid);
                            $display({"%0t:          actual slot %0d found %0d",
                                      " ev_pitch %0d ev_valid %0d pad %b"},
                                     $time, got.slot, got.found, got.evicted_pitch,
                                     got.evicted_valid, m_tdata[15:13]);
                        end
                        error_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ev.op     = s_tuser;
                ev.pitch  = s_tdata[PITCH_W-1:0];
                ev.now_us = s_tdata[PITCH_W +: NOW_W];
                owed_results.push_back(apply_voice_event(ev));
            end
            owed_total = owed_results.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int PITCH_W       = nhvt_pkg::PITCH_W;
    localparam int NOW_W         = nhvt_pkg::NOW_W;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int PHASE_EVENTS  = 232;
    localparam int HOLD_OFF_LONG = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int unsigned voice_errors;
    int unsigned results_owed;
    int unsigned send_gap_pct    = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned cycle_count;
    logic [PITCH_W-1:0] recent_pitches [$];

    note_history_voice_tracker_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    voice_history_checker voice_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .voice_errors (voice_errors),
        .results_owed (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL note_history_voice_tracker_unit");
        $finish;
    end

    // The receiver counts down a long hold-off on its own before returning to random stalls.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles != 0) begin
                m_tready = 1'b0;
                hold_off_cycles--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_event(input logic op, input logic [PITCH_W-1:0] pitch,
                              input logic [NOW_W-1:0] now_us);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {1'b0, now_us, pitch};
        do @(posedge aclk); while (!s_tready);
        if (op == nhvt_pkg::OP_NOTE_ON) begin
            recent_pitches.push_front(pitch);
            if (recent_pitches.size() > 12) begin
                void'(recent_pitches.pop_back());
            end
        end
    endtask

    // Most note offs release a pitch that was played lately; the rest are strays.
    task automatic send_random_event();
        logic               op;
        logic [PITCH_W-1:0] pitch;
        logic [NOW_W-1:0]   stamp;
        op = ($urandom_range(99) < 45) ? nhvt_pkg::OP_NOTE_OFF : nhvt_pkg::OP_NOTE_ON;
        case ($urandom_range(9))
            0: begin
                stamp = '0;
            end
            1: begin
                stamp = '1;
            end
            default: begin
                stamp = $urandom();
            end
        endcase
        if (op == nhvt_pkg::OP_NOTE_OFF && recent_pitches.size() != 0 &&
            $urandom_range(99) < 80) begin
            pitch = recent_pitches[$urandom_range(recent_pitches.size() - 1)];
        end else if ($urandom_range(99) < 55) begin
            pitch = PITCH_W'(60 + $urandom_range(7));
        end else begin
            pitch = PITCH_W'($urandom_range(127));
        end
        send_event(op, pitch, stamp);
    endtask

    initial begin
        int unsigned gap_table   [4] = '{0, 51, 0, 9};
        int unsigned stall_table [4] = '{0, 0, 51, 9};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = nhvt_pkg::OP_NOTE_ON;
        s_tdata  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_event(nhvt_pkg::OP_NOTE_OFF, 7'd0, '1);
        send_event(nhvt_pkg::OP_NOTE_ON, 7'd127, '1);
        send_event(nhvt_pkg::OP_NOTE_ON, 7'd0, '0);
        send_event(nhvt_pkg::OP_NOTE_OFF, 7'd127, '0);
        send_event(nhvt_pkg::OP_NOTE_OFF, 7'd127, '1);
        send_event(nhvt_pkg::OP_NOTE_ON, 7'd0, 32'h5555_aaaa);
        send_event(nhvt_pkg::OP_NOTE_OFF, 7'd0, 32'haaaa_5555);
        for (int i = 0; i < 7; i++) begin
            send_event(nhvt_pkg::OP_NOTE_ON, PITCH_W'(60 + i), $urandom());
        end
        send_event(nhvt_pkg::OP_NOTE_OFF, 7'd0, 32'h8000_0001);
        send_event(nhvt_pkg::OP_NOTE_OFF, 7'd42, 32'h0000_0001);
        send_event(nhvt_pkg::OP_NOTE_OFF, 7'd60, '1);
        send_event(nhvt_pkg::OP_NOTE_ON, 7'd85, '0);
        send_event(nhvt_pkg::OP_NOTE_ON, 7'd42, '0);
        send_event(nhvt_pkg::OP_NOTE_OFF, 7'd127, 32'h1234_5678);

        for (int p = 0; p < 4; p++) begin
            send_gap_pct   = gap_table[p];
            recv_stall_pct = stall_table[p];
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (p == 2 && n == 20) begin
                    hold_off_cycles = HOLD_OFF_LONG;
                end
                send_random_event();
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (results_owed != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (voice_errors == 0 && results_owed == 0) begin
            $display("PASS note_history_voice_tracker_unit");
        end else begin
            $display("FAIL note_history_voice_tracker_unit");
        end
        $finish;
    end

endmodule
